// ===== rtl/wfcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the wait-for graph cycle detector.
package wfcd_pkg;

  localparam int SLOT_W     = 4;   // width of a slot field on the ports
  localparam int RESULT_CAP = 16;  // most members reported for one cycle
  localparam int K_W        = 4;   // counts 0 .. RESULT_CAP-1

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_CLR  = 2'd1,
    REQ_FIND = 2'd2
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_QCHK,
    ST_SCAN,
    ST_POP,
    ST_ROW,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } wfcd_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] waiter_txn;
    logic [SLOT_W-1:0] holder_txn;
    logic [SLOT_W-1:0] start_txn;
  } in_req_t;

  typedef struct packed {
    logic              cycle_found;
    logic [SLOT_W-1:0] member_txn;
    logic              last;
  } out_rsp_t;

endpackage

// ===== rtl/wfcd_adj_store.sv =====
`timescale 1ns / 1ps
// Adjacency matrix store: one row per waiter, registered read, per-row valid bits.
module wfcd_adj_store import wfcd_pkg::*; #(
  parameter int MAX_TXNS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [$clog2(MAX_TXNS)-1:0] rd_addr,
  output logic [MAX_TXNS-1:0]         rd_row,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_TXNS)-1:0] wr_addr,
  input  logic [MAX_TXNS-1:0]         wr_row
);

  logic [MAX_TXNS-1:0] mem [MAX_TXNS];
  logic [MAX_TXNS-1:0] row_vld_r;
  logic [MAX_TXNS-1:0] rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= row_vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_row = rd_row_r;

endmodule

// ===== rtl/wait_for_cycle_detector_top.sv =====
`timescale 1ns / 1ps
// Top level of the wait-for graph cycle detector: request sequencer, DFS walk, path stack.
// Edge set/clear: row read at accept, row write back, busy high 1 cycle; no result.
// Query: fetch the start row, then test one neighbor bit at a time, with an end-of-row
//   test per row, a row fetch per push, and a parent read and row fetch per pop.
// On a cycle: the stack is scanned entry by entry to find the entry slot, then one out_valid
//   strobe per member (at most 16). A request is taken whenever busy is low; no output stall.
// Reset (rst_n low, synchronous) empties the graph via per-row valid bits and clears the marks.
module wait_for_cycle_detector_top import wfcd_pkg::*; #(
  parameter int MAX_TXNS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int IDX_W = $clog2(MAX_TXNS);
  localparam int CNT_W = $clog2(MAX_TXNS + 1);
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // port slot -> internal index (truncate or extend)
  function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
    logic [EXT_W-1:0] e;
    e = EXT_W'(s);
    return e[IDX_W-1:0];
  endfunction

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return 32'(s) < MAX_TXNS;
  endfunction

  wfcd_state_t state_r, state_nxt;

  // sequencer and mark state
  logic [MAX_TXNS-1:0] gray_r, black_r;
  logic [CNT_W-1:0]    depth_r;
  logic                out_valid_r;

  // payload registers
  in_req_t             req_r;
  logic [IDX_W-1:0]    u_r;        // node being expanded
  logic [CNT_W-1:0]    v_r;        // neighbor under test, MAX_TXNS = row exhausted
  logic [MAX_TXNS-1:0] row_r;      // adjacency row of u_r
  logic [IDX_W-1:0]    tgt_r;      // gray node closing the cycle
  logic [IDX_W-1:0]    p_r;        // stack scan pointer
  logic [IDX_W-1:0]    e_addr_r;   // stack entry being emitted
  logic [K_W-1:0]      k_r;
  logic [K_W-1:0]      n_m1_r;     // members to emit, minus one
  out_rsp_t            out_rsp_r;

  // path stack memory
  logic [IDX_W-1:0] stk_mem [MAX_TXNS];
  logic [IDX_W-1:0] stk_rd_r;
  logic             stk_we;
  logic [IDX_W-1:0] stk_wa, stk_wd, stk_ra;

  // adjacency store port
  logic [IDX_W-1:0]    adj_rd_addr;
  logic [MAX_TXNS-1:0] adj_row;
  logic                adj_we;
  logic [MAX_TXNS-1:0] adj_wd;
  logic [MAX_TXNS-1:0] hbit;

  // decode
  logic             accept;
  req_type_t        in_type;
  logic [IDX_W-1:0] vi;
  logic             scan_end, hit, cyc, push, depth_full, depth_one;
  logic             match, out_fire;
  logic [CNT_W-1:0] dm2, rem, rem_m1, u_p1;
  logic [EXT_W-1:0] member_ext;

  assign accept     = start && !busy;
  assign in_type    = req_type_t'(in_req.req_type);
  assign vi         = v_r[IDX_W-1:0];
  assign scan_end   = (v_r == CNT_W'(MAX_TXNS));
  assign hit        = !scan_end && row_r[vi];
  assign cyc        = hit && gray_r[vi];
  assign depth_full = (depth_r == CNT_W'(MAX_TXNS));
  assign push       = hit && !gray_r[vi] && !black_r[vi] && !depth_full;
  assign depth_one  = (depth_r == CNT_W'(1));
  assign dm2        = depth_r - CNT_W'(2);
  assign u_p1       = CNT_W'(u_r) + CNT_W'(1);
  assign match      = (stk_rd_r == tgt_r);
  assign rem        = depth_r - CNT_W'(p_r);
  assign rem_m1     = rem - CNT_W'(1);
  assign member_ext = EXT_W'(stk_rd_r);
  assign hbit       = MAX_TXNS'(1) << to_idx(req_r.holder_txn);

  // results that come straight from the sequencer
  always_comb begin
    out_fire = 1'b0;
    case (state_r)
      ST_IDLE:     out_fire = accept && (in_type == REQ_FIND) && !slot_ok(in_req.start_txn);
      ST_QCHK:     out_fire = (adj_row == '0);
      ST_SCAN:     out_fire = scan_end && depth_one;
      ST_EMIT_OUT: out_fire = 1'b1;
      default:     out_fire = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_type)
            REQ_SET, REQ_CLR: state_nxt = ST_EDGE;
            REQ_FIND:         state_nxt = slot_ok(in_req.start_txn) ? ST_QCHK : ST_IDLE;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EDGE: state_nxt = ST_IDLE;
      ST_QCHK: state_nxt = (adj_row == '0) ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (scan_end)  state_nxt = depth_one ? ST_IDLE : ST_POP;
        else if (cyc)  state_nxt = ST_FIND_RD;
        else if (push) state_nxt = ST_ROW;
        else           state_nxt = ST_SCAN;
      end
      ST_POP:      state_nxt = ST_ROW;
      ST_ROW:      state_nxt = ST_SCAN;
      ST_FIND_RD:  state_nxt = ST_FIND_CMP;
      ST_FIND_CMP: state_nxt = match ? ST_EMIT_RD : ST_FIND_RD;
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: state_nxt = (k_r == n_m1_r) ? ST_IDLE : ST_EMIT_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    adj_rd_addr = u_r;
    adj_we      = 1'b0;
    adj_wd      = (req_type_t'(req_r.req_type) == REQ_SET) ? (adj_row | hbit)
                                                           : (adj_row & ~hbit);
    stk_we      = 1'b0;
    stk_wa      = depth_r[IDX_W-1:0];
    stk_wd      = vi;
    stk_ra      = p_r;
    case (state_r)
      ST_IDLE: begin
        adj_rd_addr = (in_type == REQ_FIND) ? to_idx(in_req.start_txn)
                                            : to_idx(in_req.waiter_txn);
      end
      ST_EDGE: begin
        adj_we = slot_ok(req_r.waiter_txn) && slot_ok(req_r.holder_txn);
      end
      ST_QCHK: begin
        stk_we = (adj_row != '0);
        stk_wa = '0;
        stk_wd = to_idx(req_r.start_txn);
      end
      ST_SCAN: begin
        if (scan_end) begin
          stk_ra = dm2[IDX_W-1:0];  // parent entry
        end else if (push) begin
          stk_we      = 1'b1;
          adj_rd_addr = vi;
        end
      end
      ST_POP:     adj_rd_addr = stk_rd_r;
      ST_FIND_RD: stk_ra = p_r;
      ST_EMIT_RD: stk_ra = e_addr_r;
      default: ;
    endcase
  end

  wfcd_adj_store #(
    .MAX_TXNS(MAX_TXNS)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (adj_rd_addr),
    .rd_row  (adj_row),
    .wr_en   (adj_we),
    .wr_addr (to_idx(req_r.waiter_txn)),
    .wr_row  (adj_wd)
  );

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gray_r      <= '0;
      black_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_fire;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_type == REQ_FIND) begin
            gray_r  <= '0;
            black_r <= '0;
            depth_r <= '0;
          end
        end
        ST_QCHK: begin
          if (adj_row != '0) begin
            gray_r[to_idx(req_r.start_txn)] <= 1'b1;
            depth_r <= CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            black_r[u_r] <= 1'b1;
            gray_r[u_r]  <= 1'b0;
            depth_r      <= depth_r - CNT_W'(1);
          end else if (push) begin
            gray_r[vi] <= 1'b1;
            depth_r    <= depth_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) req_r <= in_req;
      end
      ST_QCHK: begin
        u_r   <= to_idx(req_r.start_txn);
        v_r   <= '0;
        row_r <= adj_row;
      end
      ST_SCAN: begin
        if (scan_end) begin
          v_r <= u_p1;  // resume parent just past the popped child
        end else if (cyc) begin
          tgt_r <= vi;
          p_r   <= '0;
        end else if (push) begin
          u_r <= vi;
          v_r <= '0;
        end else begin
          v_r <= v_r + CNT_W'(1);
        end
      end
      ST_POP: u_r   <= stk_rd_r;
      ST_ROW: row_r <= adj_row;
      ST_FIND_CMP: begin
        if (match) begin
          e_addr_r <= p_r;
          k_r      <= '0;
          n_m1_r   <= (32'(rem_m1) >= RESULT_CAP) ? K_W'(RESULT_CAP - 1) : K_W'(rem_m1);
        end else begin
          p_r <= p_r + IDX_W'(1);
        end
      end
      ST_EMIT_OUT: begin
        e_addr_r <= e_addr_r + IDX_W'(1);
        k_r      <= k_r + K_W'(1);
      end
      default: ;
    endcase

    if (out_fire) begin
      if (state_r == ST_EMIT_OUT) begin
        out_rsp_r.cycle_found <= 1'b1;
        out_rsp_r.member_txn  <= member_ext[SLOT_W-1:0];
        out_rsp_r.last        <= (k_r == n_m1_r);
      end else begin
        out_rsp_r.cycle_found <= 1'b0;
        out_rsp_r.member_txn  <= '0;
        out_rsp_r.last        <= 1'b1;
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // a no-cycle report is always the only result of its request
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.cycle_found |-> out_rsp.last)
    else $error("no-cycle result without last");

  // the node under expansion stays gray while its row is scanned
  a_u_gray: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> gray_r[u_r])
    else $error("expanded node not gray");

  // the walk never scans with an empty path
  a_depth_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN || state_r == ST_POP |-> depth_r != '0)
    else $error("scan with empty path");

  // a result only follows work on a request
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without request");

endmodule

// ===== tb/wait_for_cycle_detector_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the wait-for graph cycle detector: table-driven and random requests.
module wait_for_cycle_detector_top_tb;
  import wfcd_pkg::*;

  localparam int NUM_SLOTS    = 16;          // matches the default MAX_TXNS of the block
  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 190;
  localparam int DRAIN_GUARD  = 4000;        // cycles allowed for outstanding results
  localparam int SETTLE_CYCLS = 500;         // > worst query: row scans + pushes/pops + emit
  localparam int EDGE_CEILING = 20;          // keep the graph sparse so searches stay varied

  // Request code 3 is not defined by the package; the block must ignore it.
  localparam logic [1:0] REQ_RSVD = 2'd3;

  // DFS node colors used by the search predictor.
  typedef enum logic [1:0] {
    MARK_WHITE,
    MARK_GRAY,
    MARK_BLACK
  } node_mark_t;

  // One directed row: the request and, where it is obvious, the one result it gives.
  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_rsp_t rsp;
  } stim_row_t;

  localparam out_rsp_t NO_CYCLE = '{cycle_found: 1'b0, member_txn: 4'd0, last: 1'b1};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_rsp_t out_rsp;

  // Predictor state: row w, bit h set means slot w waits for slot h.
  logic [NUM_SLOTS-1:0] wait_graph [NUM_SLOTS];
  out_rsp_t             expected_members [$];
  out_rsp_t             want_rsp;
  stim_row_t            directed_rows [N_DIRECTED];

  int mismatches = 0;
  int req_sent   = 0;
  bit idle_en    = 1'b1;

  always #4 clk = ~clk;

  wait_for_cycle_detector_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) wait_graph[i] = '0;
  end

  function automatic in_req_t mk_req(logic [1:0] op, int w, int h, int s);
    in_req_t r;
    r.req_type   = op;
    r.waiter_txn = w[SLOT_W-1:0];
    r.holder_txn = h[SLOT_W-1:0];
    r.start_txn  = s[SLOT_W-1:0];
    return r;
  endfunction

  // Append one expected result at the tail of the queue.
  function automatic void expect_rsp(out_rsp_t rsp);
    expected_members.insert(expected_members.size(), rsp);
  endfunction

  // Iterative DFS from root with white/gray/black marks, neighbors in ascending
  // slot order. Reaching a gray slot closes a cycle: the path from that slot to
  // the current top of stack is what the block reports, one member per result.
  function automatic void walk_wait_graph(logic [SLOT_W-1:0] root);
    node_mark_t        mark [NUM_SLOTS];
    logic [SLOT_W-1:0] path [NUM_SLOTS];
    int                scan_from [NUM_SLOTS];
    int                depth, top, v, p, n;
    logic [SLOT_W-1:0] u;
    out_rsp_t          rsp;
    for (int i = 0; i < NUM_SLOTS; i++) mark[i] = MARK_WHITE;
    if (wait_graph[root] == '0) begin
      expect_rsp(NO_CYCLE);
      return;
    end
    mark[root]   = MARK_GRAY;
    path[0]      = root;
    scan_from[0] = 0;
    depth        = 1;
    while (depth > 0) begin
      top = depth - 1;
      u   = path[top];
      v   = scan_from[top];
      while (v < NUM_SLOTS && !wait_graph[u][v]) v++;
      if (v >= NUM_SLOTS) begin
        mark[u] = MARK_BLACK;   // fully explored, back out
        depth--;
        continue;
      end
      scan_from[top] = v + 1;
      if (mark[v] == MARK_GRAY) begin
        p = 0;
        while (p < depth && path[p] != v) p++;
        n = depth - p;
        if (n > RESULT_CAP) n = RESULT_CAP;
        for (int k = 0; k < n; k++) begin
          rsp.cycle_found = 1'b1;
          rsp.member_txn  = path[p + k];
          rsp.last        = (k == n - 1);
          expect_rsp(rsp);
        end
        return;
      end
      if (mark[v] == MARK_WHITE && depth < NUM_SLOTS) begin
        mark[v]          = MARK_GRAY;
        path[depth]      = v[SLOT_W-1:0];
        scan_from[depth] = 0;
        depth++;
      end
    end
    expect_rsp(NO_CYCLE);
  endfunction

  function automatic void predict_request(in_req_t r);
    case (r.req_type)
      REQ_SET:  wait_graph[r.waiter_txn][r.holder_txn] = 1'b1;
      REQ_CLR:  wait_graph[r.waiter_txn][r.holder_txn] = 1'b0;
      REQ_FIND: walk_wait_graph(r.start_txn);
      default: ;   // reserved code: no effect, no result
    endcase
  endfunction

  // Offer one request; random idle cycles before it carry junk on in_req.
  // start stays high through busy, so the request is taken on the first
  // edge with busy low. Expectations are queued at that edge.
  task automatic send_request(in_req_t r, bit use_typed = 1'b0, out_rsp_t typed_rsp = '0);
    while (idle_en && $urandom_range(99) < 27) begin
      start  <= 1'b0;
      in_req <= in_req_t'($urandom);
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    if (use_typed) expect_rsp(typed_rsp);
    else predict_request(r);
    if (r.req_type != REQ_RSVD) req_sent++;
  endtask

  // Hold the sender off until every outstanding result has shown up.
  task automatic drain_expected();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (expected_members.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic tear_down_graph();
    for (int w = 0; w < NUM_SLOTS; w++)
      for (int h = 0; h < NUM_SLOTS; h++)
        if (wait_graph[w][h]) send_request(mk_req(REQ_CLR, w, h, $urandom_range(15)));
  endtask

  function automatic int edge_count();
    int c;
    c = 0;
    for (int w = 0; w < NUM_SLOTS; w++) c += $countones(wait_graph[w]);
    return c;
  endfunction

  // Well-formed deadlock: a ring over shuffled slots, an optional waiter
  // feeding into it, a little noise, then queries from members and the tail.
  task automatic build_cycle();
    int order [NUM_SLOTS];
    int len, j, tmp, span;
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    len  = ($urandom_range(5) == 0) ? NUM_SLOTS : $urandom_range(6, 1);
    span = (len < NUM_SLOTS) ? len : NUM_SLOTS - 1;
    for (int i = 0; i < len; i++)
      send_request(mk_req(REQ_SET, order[i], order[(i + 1) % len], $urandom_range(15)));
    if (len < NUM_SLOTS && $urandom_range(1))
      send_request(mk_req(REQ_SET, order[len], order[$urandom_range(len - 1)],
                          $urandom_range(15)));
    repeat ($urandom_range(2))
      send_request(mk_req(REQ_SET, $urandom_range(15), $urandom_range(15), $urandom_range(15)));
    repeat ($urandom_range(3, 1))
      send_request(mk_req(REQ_FIND, $urandom_range(15), $urandom_range(15),
                          order[$urandom_range(span)]));
    if ($urandom_range(2) == 0) begin
      // break the ring and look again
      j = $urandom_range(len - 1);
      send_request(mk_req(REQ_CLR, order[j], order[(j + 1) % len], $urandom_range(15)));
      send_request(mk_req(REQ_FIND, $urandom_range(15), $urandom_range(15), order[j]));
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_members.size() == 0) begin
        $error("unexpected result: cycle_found %0b member_txn %0d last %0b",
               out_rsp.cycle_found, out_rsp.member_txn, out_rsp.last);
        mismatches++;
      end else begin
        want_rsp = expected_members.pop_front();
        if (out_rsp.cycle_found !== want_rsp.cycle_found) begin
          $error("cycle_found: expected %0b, got %0b", want_rsp.cycle_found,
                 out_rsp.cycle_found);
          mismatches++;
        end
        if (out_rsp.member_txn !== want_rsp.member_txn) begin
          $error("member_txn: expected %0d, got %0d", want_rsp.member_txn, out_rsp.member_txn);
          mismatches++;
        end
        if (out_rsp.last !== want_rsp.last) begin
          $error("last: expected %0b, got %0b", want_rsp.last, out_rsp.last);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random scenarios, drain, verdict.
  initial begin
    // typed = 1 rows carry their single result; others go through the predictor
    directed_rows = '{
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd0},  1'b1, NO_CYCLE},   // empty graph after reset
      '{'{REQ_FIND, 4'd15, 4'd15, 4'd15}, 1'b1, NO_CYCLE},   // highest slot, no edges
      '{'{REQ_SET,  4'd5,  4'd5,  4'd15}, 1'b0, NO_CYCLE},   // self wait
      '{'{REQ_FIND, 4'd15, 4'd15, 4'd5},  1'b1, '{1'b1, 4'd5, 1'b1}},
      '{'{REQ_CLR,  4'd5,  4'd5,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd5},  1'b1, NO_CYCLE},
      '{'{REQ_RSVD, 4'd15, 4'd15, 4'd15}, 1'b0, NO_CYCLE},   // reserved code, ignored
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd15}, 1'b1, NO_CYCLE},
      '{'{REQ_SET,  4'd0,  4'd15, 4'd15}, 1'b0, NO_CYCLE},   // extremes: 0 <-> 15
      '{'{REQ_SET,  4'd15, 4'd0,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_FIND, 4'd15, 4'd15, 4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd15}, 1'b0, NO_CYCLE},
      '{'{REQ_SET,  4'd3,  4'd0,  4'd0},  1'b0, NO_CYCLE},   // tail into the pair
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd3},  1'b0, NO_CYCLE},
      '{'{REQ_SET,  4'd1,  4'd2,  4'd0},  1'b0, NO_CYCLE},   // chain to a dead end
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd1},  1'b1, NO_CYCLE},
      '{'{REQ_SET,  4'd2,  4'd2,  4'd0},  1'b0, NO_CYCLE},   // self wait at chain end
      '{'{REQ_FIND, 4'd0,  4'd0,  4'd1},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd15, 4'd0,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_FIND, 4'd15, 4'd15, 4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd0,  4'd15, 4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd3,  4'd0,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd1,  4'd2,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd2,  4'd2,  4'd0},  1'b0, NO_CYCLE},
      '{'{REQ_CLR,  4'd15, 4'd15, 4'd15}, 1'b0, NO_CYCLE}    // clear an absent edge
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // sender waits out every pending result once before the random part
    drain_expected();

    while (req_sent < N_DIRECTED + N_RANDOM) begin
      // a stretch in the middle runs back to back
      idle_en = !(req_sent >= 120 && req_sent < 170);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: build_cycle();
        6, 7: repeat (6) send_request(in_req_t'($urandom));
        8: begin
          drain_expected();
          send_request(mk_req(REQ_FIND, $urandom_range(15), $urandom_range(15),
                              $urandom_range(15)));
        end
        default: tear_down_graph();
      endcase
      if (edge_count() > EDGE_CEILING) tear_down_graph();
    end

    drain_expected();
    repeat (SETTLE_CYCLS) @(posedge clk);
    while (expected_members.size() != 0) begin
      want_rsp = expected_members.pop_front();
      $error("missing result: cycle_found %0b member_txn %0d last %0b",
             want_rsp.cycle_found, want_rsp.member_txn, want_rsp.last);
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("wait_for_cycle_detector_top verification clean");
    end else begin
      $display("wait_for_cycle_detector_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("wait_for_cycle_detector_top verification failed");
    $finish;
  end

endmodule
